[rtl/core/gray_code_correspondence_match_defines.svh]
// ----------------------------------------------------------------------------
// gray code correspondence match assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef GRAY_CODE_CORRESPONDENCE_MATCH_DEFINES_SVH
`define GRAY_CODE_CORRESPONDENCE_MATCH_DEFINES_SVH

// same-cycle implication, off during reset
`define GCCM_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define GCCM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also covers reset
`define GCCM_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/gccm_pkg.sv]
// ----------------------------------------------------------------------------
// gccm_pkg
// shared types and constants of the gray code correspondence matcher
// ----------------------------------------------------------------------------
package gccm_pkg;

   // request kinds
   localparam logic REQ_STORE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COL_CODE_BITS = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_CODE_BITS = 1'b1;
   localparam logic [CSR_DATA_BITS-1:0]  COL_CODE_BITS_RESET = 4'd10;

   // projector coordinates and the query code before truncation
   localparam int PROJ_COORD_BITS = 10;
   localparam int PROJ_GRAY_BITS  = PROJ_COORD_BITS + 1;
   localparam int MAX_SHIFT       = (1 << CSR_DATA_BITS) - 1;
   localparam int QUERY_CODE_BITS = PROJ_GRAY_BITS + MAX_SHIFT;

   // queue depths
   localparam int MID_FIFO_DEPTH = 4;
   localparam int OUT_FIFO_DEPTH = 4;

   typedef struct packed {
      logic full;
      logic afull;
      logic empty;
   } fifo_status_type;

endpackage

[rtl/core/gray_code_correspondence_match.sv]
// ----------------------------------------------------------------------------
// gray_code_correspondence_match
// matches projector pixels to camera pixels through a gray code table
// ----------------------------------------------------------------------------
// req_* is a queue input: an item enters when req_push is high and req_full
// is low. req_type 0 stores the camera position under its code, req_type 1
// queries a projector pixel. rsp_* is a queue output: the oldest result sits
// on the ports while rsp_empty is low and leaves when rsp_pop is high.
// csr_we writes col_code_bits (index 0) at once; index 1 is accepted and has
// no effect on the lookup. Write it only while no item is in flight.
// Throughput is one item per cycle, set by the single table port, while the
// output queue has room for queries. A query result goes through the front
// register, middle queue, table read register and output queue; a store
// goes through the first two into the table, seen by every later query.
// After reset the table is cleared one entry per cycle, req_full held high.
// When the receiver stalls, results wait in a 4-entry output queue; the front
// keeps taking items until the middle queue fills, then req_full rises.
// ----------------------------------------------------------------------------
module gray_code_correspondence_match #(
   parameter int CODE_BITS      = 20,
   parameter int CAM_COORD_BITS = 11
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [gccm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [gccm_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic                                  req_type,
   input  logic [CAM_COORD_BITS-1:0]             req_cam_col,
   input  logic [CAM_COORD_BITS-1:0]             req_cam_row,
   input  logic [CODE_BITS-1:0]                  req_cam_code,
   input  logic [gccm_pkg::PROJ_COORD_BITS-1:0]  req_proj_col,
   input  logic [gccm_pkg::PROJ_COORD_BITS-1:0]  req_proj_row,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [gccm_pkg::PROJ_COORD_BITS-1:0]  rsp_out_proj_col,
   output logic [gccm_pkg::PROJ_COORD_BITS-1:0]  rsp_out_proj_row,
   output logic [CAM_COORD_BITS-1:0]             rsp_out_cam_col,
   output logic [CAM_COORD_BITS-1:0]             rsp_out_cam_row,
   output logic [CODE_BITS:0]                    rsp_match_number
);

   localparam int OP_BITS  = 1 + CODE_BITS + 2 * CAM_COORD_BITS
                             + 2 * gccm_pkg::PROJ_COORD_BITS;
   localparam int RES_BITS = 2 * gccm_pkg::PROJ_COORD_BITS
                             + 2 * CAM_COORD_BITS + CODE_BITS + 1;

   logic                      clearing;
   logic                      front_valid;
   logic [OP_BITS-1:0]        front_data;
   gccm_pkg::fifo_status_type mid_status;
   logic [OP_BITS-1:0]        mid_data;
   logic                      mid_pop;
   gccm_pkg::fifo_status_type out_status;
   logic                      out_push;
   logic [RES_BITS-1:0]       out_push_data;
   logic [RES_BITS-1:0]       out_data;

   gccm_front #(
      .CODE_BITS      (CODE_BITS),
      .CAM_COORD_BITS (CAM_COORD_BITS),
      .OP_BITS        (OP_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (req_push),
      .full      (req_full),
      .clearing  (clearing),
      .req_type  (req_type),
      .cam_col   (req_cam_col),
      .cam_row   (req_cam_row),
      .cam_code  (req_cam_code),
      .proj_col  (req_proj_col),
      .proj_row  (req_proj_row),
      .op_valid  (front_valid),
      .op_data   (front_data),
      .op_ready  (!mid_status.full)
   );

   gccm_fifo #(
      .WIDTH (OP_BITS),
      .DEPTH (gccm_pkg::MID_FIFO_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_data),
      .pop       (mid_pop),
      .pop_data  (mid_data),
      .status    (mid_status)
   );

   gccm_back #(
      .CODE_BITS      (CODE_BITS),
      .CAM_COORD_BITS (CAM_COORD_BITS),
      .OP_BITS        (OP_BITS),
      .RES_BITS       (RES_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .clearing   (clearing),
      .op_valid   (!mid_status.empty),
      .op_data    (mid_data),
      .op_pop     (mid_pop),
      .out_status (out_status),
      .out_push   (out_push),
      .out_data   (out_push_data)
   );

   gccm_fifo #(
      .WIDTH (RES_BITS),
      .DEPTH (gccm_pkg::OUT_FIFO_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_push_data),
      .pop       (rsp_pop),
      .pop_data  (out_data),
      .status    (out_status)
   );

   assign rsp_empty = out_status.empty;
   assign {rsp_out_proj_col, rsp_out_proj_row, rsp_out_cam_col, rsp_out_cam_row,
           rsp_match_number} = out_data;

endmodule

[rtl/core/gccm_fifo.sv]
// ----------------------------------------------------------------------------
// gccm_fifo
// small register queue with full, almost full and empty status
// ----------------------------------------------------------------------------
module gccm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        push_data,
   input  logic                    pop,
   output logic [WIDTH-1:0]        pop_data,
   output gccm_pkg::fifo_status_type status
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    data_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push_ok;
   logic                pop_ok;

   assign status.full  = (count_ff == CNT_BITS'(DEPTH));
   assign status.afull = (count_ff >= CNT_BITS'(DEPTH - 1));
   assign status.empty = (count_ff == '0);

   assign push_ok  = push && !status.full;
   assign pop_ok   = pop && !status.empty;
   assign pop_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/gccm_front.sv]
// ----------------------------------------------------------------------------
// gccm_front
// accepts items, forms the table code and drops items with code zero
// ----------------------------------------------------------------------------
module gccm_front #(
   parameter int CODE_BITS      = 20,
   parameter int CAM_COORD_BITS = 11,
   parameter int OP_BITS        = 1 + CODE_BITS + 2 * CAM_COORD_BITS
                                  + 2 * gccm_pkg::PROJ_COORD_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [gccm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [gccm_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                  push,
   output logic                                  full,
   input  logic                                  clearing,
   input  logic                                  req_type,
   input  logic [CAM_COORD_BITS-1:0]             cam_col,
   input  logic [CAM_COORD_BITS-1:0]             cam_row,
   input  logic [CODE_BITS-1:0]                  cam_code,
   input  logic [gccm_pkg::PROJ_COORD_BITS-1:0]  proj_col,
   input  logic [gccm_pkg::PROJ_COORD_BITS-1:0]  proj_row,
   output logic                                  op_valid,
   output logic [OP_BITS-1:0]                    op_data,
   input  logic                                  op_ready
);

   logic [gccm_pkg::CSR_DATA_BITS-1:0]   col_code_bits_ff, col_code_bits_in;
   logic                                 op_valid_ff, op_valid_in;
   logic [OP_BITS-1:0]                   op_data_ff, op_data_in;
   logic [gccm_pkg::PROJ_GRAY_BITS-1:0]  col_inc, row_inc;
   logic [gccm_pkg::PROJ_GRAY_BITS-1:0]  col_gray, row_gray;
   logic [gccm_pkg::QUERY_CODE_BITS-1:0] query_wide;
   logic [CODE_BITS-1:0]                 code;
   logic                                 accept;

   // gray(v) = v ^ (v >> 1), row code sits above the column code
   assign col_inc    = {1'b0, proj_col} + 1'b1;
   assign row_inc    = {1'b0, proj_row} + 1'b1;
   assign col_gray   = col_inc ^ (col_inc >> 1);
   assign row_gray   = row_inc ^ (row_inc >> 1);
   assign query_wide = (gccm_pkg::QUERY_CODE_BITS'(row_gray) << col_code_bits_ff)
                     | gccm_pkg::QUERY_CODE_BITS'(col_gray);
   assign code       = (req_type == gccm_pkg::REQ_QUERY) ? query_wide[CODE_BITS-1:0]
                                                         : cam_code;

   assign full     = clearing || (op_valid_ff && !op_ready);
   assign accept   = push && !full;
   assign op_valid = op_valid_ff;
   assign op_data  = op_data_ff;

   always_comb begin
      col_code_bits_in = col_code_bits_ff;
      if (csr_we) begin
         case (csr_index)
            gccm_pkg::CSR_COL_CODE_BITS: col_code_bits_in = csr_wdata;
            gccm_pkg::CSR_ROW_CODE_BITS: col_code_bits_in = col_code_bits_ff;
            default:                     col_code_bits_in = col_code_bits_ff;
         endcase
      end
   end

   always_comb begin
      op_valid_in = op_valid_ff;
      op_data_in  = op_data_ff;
      if (accept) begin
         op_valid_in = (code != '0);
         op_data_in  = {req_type, code, cam_col, cam_row, proj_col, proj_row};
      end else if (op_ready) begin
         op_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_code_bits_ff <= gccm_pkg::COL_CODE_BITS_RESET;
         op_valid_ff      <= 1'b0;
      end else begin
         col_code_bits_ff <= col_code_bits_in;
         op_valid_ff      <= op_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_data_ff <= op_data_in;
   end

endmodule

[rtl/core/gccm_back.sv]
// ----------------------------------------------------------------------------
// gccm_back
// code table: clears after reset, then stores positions and answers queries
// ----------------------------------------------------------------------------
module gccm_back #(
   parameter int CODE_BITS      = 20,
   parameter int CAM_COORD_BITS = 11,
   parameter int OP_BITS        = 1 + CODE_BITS + 2 * CAM_COORD_BITS
                                  + 2 * gccm_pkg::PROJ_COORD_BITS,
   parameter int RES_BITS       = 2 * gccm_pkg::PROJ_COORD_BITS
                                  + 2 * CAM_COORD_BITS + CODE_BITS + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   output logic                      clearing,
   input  logic                      op_valid,
   input  logic [OP_BITS-1:0]        op_data,
   output logic                      op_pop,
   input  gccm_pkg::fifo_status_type out_status,
   output logic                      out_push,
   output logic [RES_BITS-1:0]       out_data
);

   localparam int TABLE_DEPTH = 1 << CODE_BITS;
   localparam int ENTRY_BITS  = 1 + 2 * CAM_COORD_BITS;

   logic [ENTRY_BITS-1:0] table_mem [TABLE_DEPTH];

   logic [CODE_BITS:0]                   clr_addr_ff, clr_addr_in;
   logic                                 rd_pend_ff, rd_pend_in;
   logic [CODE_BITS:0]                   match_cnt_ff, match_cnt_in;
   logic [ENTRY_BITS-1:0]                rd_entry_ff;
   logic [gccm_pkg::PROJ_COORD_BITS-1:0] rd_proj_col_ff, rd_proj_row_ff;

   logic                                 op_is_query;
   logic [CODE_BITS-1:0]                 op_code;
   logic [CAM_COORD_BITS-1:0]            op_cam_col, op_cam_row;
   logic [gccm_pkg::PROJ_COORD_BITS-1:0] op_proj_col, op_proj_row;
   logic                                 room;
   logic                                 issue;
   logic                                 mem_we, mem_re;
   logic [CODE_BITS-1:0]                 mem_addr;
   logic [ENTRY_BITS-1:0]                mem_wdata;
   logic                                 hit;

   assign {op_is_query, op_code, op_cam_col, op_cam_row, op_proj_col, op_proj_row} = op_data;

   assign clearing = !clr_addr_ff[CODE_BITS];

   // a query needs an output slot beyond the one a read in flight may take
   assign room   = !out_status.full && !(rd_pend_ff && out_status.afull);
   assign issue  = op_valid && !clearing
                && ((op_is_query != gccm_pkg::REQ_QUERY) || room);
   assign op_pop = issue;

   assign mem_we    = clearing || (issue && (op_is_query == gccm_pkg::REQ_STORE));
   assign mem_re    = issue && (op_is_query == gccm_pkg::REQ_QUERY);
   assign mem_addr  = clearing ? clr_addr_ff[CODE_BITS-1:0] : op_code;
   assign mem_wdata = clearing ? '0 : {1'b1, op_cam_row, op_cam_col};

   assign hit      = rd_pend_ff && rd_entry_ff[ENTRY_BITS-1];
   assign out_push = hit;
   assign out_data = {rd_proj_col_ff, rd_proj_row_ff,
                      rd_entry_ff[CAM_COORD_BITS-1:0],
                      rd_entry_ff[2*CAM_COORD_BITS-1:CAM_COORD_BITS],
                      match_cnt_ff};

   always_comb begin
      clr_addr_in  = clearing ? clr_addr_ff + 1'b1 : clr_addr_ff;
      rd_pend_in   = mem_re;
      match_cnt_in = match_cnt_ff;
      if (hit && !match_cnt_ff[CODE_BITS]) begin
         match_cnt_in = match_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         match_cnt_ff <= '0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         rd_pend_ff   <= rd_pend_in;
         match_cnt_ff <= match_cnt_in;
      end
   end

   // single-port table, read data registered
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_entry_ff <= table_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_proj_col_ff <= op_proj_col;
         rd_proj_row_ff <= op_proj_row;
      end
   end

endmodule

[rtl/core/gccm_checker.sv]
// ----------------------------------------------------------------------------
// gccm_checker
// port checks of the gray code correspondence matcher, bound to the top level
// ----------------------------------------------------------------------------
`include "gray_code_correspondence_match_defines.svh"

module gccm_checker #(
   parameter int CODE_BITS = 20
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_full,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input logic [CODE_BITS:0]   rsp_match_number
);

   // reset starts the clearing pass with nothing to deliver
   `GCCM_ASSERT_NEXT_ALWAYS(a_reset_state, reset, rsp_empty && req_full, "bad state after reset")

   // consecutive results count up by one until the limit
   `GCCM_ASSERT_NEXT(a_match_step, !rsp_empty && rsp_pop && !rsp_match_number[CODE_BITS],
      rsp_empty || (rsp_match_number == $past(rsp_match_number) + 1'b1),
      "match number skipped")

   // match number saturates exactly at the table depth
   `GCCM_ASSERT_IMPLY(a_match_limit, !rsp_empty,
      !rsp_match_number[CODE_BITS] || (rsp_match_number[CODE_BITS-1:0] == '0),
      "match number beyond limit")

   // a waiting result holds until taken
   `GCCM_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_match_number), "waiting result changed")

endmodule

bind gray_code_correspondence_match gccm_checker #(
   .CODE_BITS (CODE_BITS)
) u_gccm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_match_number (rsp_match_number)
);
